@@ src/psfq_pkg.sv @@
// Shared types and constants for the priority-sorted queue.
// No dependencies; imported by the top level, priority_sorted_fifo_queue.
package psfq_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int PRIO_BITS_DEF = 8;
  localparam int ID_BITS       = 4;
  localparam int ID_COUNT      = 16;
  localparam int KIND_BITS     = 2;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_INSERT  = 2'd0,
    KIND_REMOVE  = 2'd1,
    KIND_REQUEUE = 2'd2
  } kind_t;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_HEAD_RD,
    ST_TAIL_RD,
    ST_TAIL_CAP,
    ST_DONE
  } state_t;

endpackage

@@ src/priority_sorted_fifo_queue.sv @@
// Top level of the priority-sorted queue with FIFO order among equal priorities.
// Depends on psfq_pkg and psfq_ram (sorted slot storage).
//
// Usage:
//  - Request channel (in_*): kind (insert, remove, requeue), entry id and
//    priority. A request is taken when in_valid is high and in_stall low.
//  - Result channel (out_*): one result per request: status, empty flag,
//    head id/priority, tail id and occupancy after the operation.
//  - Slots live in one RAM (id and priority per word), walked by a small
//    sequencer with one read and one write per cycle. Every step issues
//    the read, then compares and moves one slot.
//  - Throughput: one request at a time; in_stall is high while a request is
//    being worked. A new request is taken while a result still waits in the
//    output register.
//  - Reset (rst_n low, synchronous) empties the queue: count and membership
//    map clear at once, no clearing pass over the RAM.
//  - When out_stall holds the output register, the finished request waits in
//    its last state until the register frees up.
module priority_sorted_fifo_queue
  import psfq_pkg::*;
#(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int PRIORITY_BITS = PRIO_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [KIND_BITS-1:0]             in_kind,
  input  logic [ID_BITS-1:0]               in_entry_id,
  input  logic [PRIORITY_BITS-1:0]         in_priority_req,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_status,
  output logic                             out_is_empty,
  output logic [ID_BITS-1:0]               out_head_id,
  output logic [PRIORITY_BITS-1:0]         out_head_priority,
  output logic [ID_BITS-1:0]               out_tail_id,
  output logic [$clog2(CAPACITY+1)-1:0]    out_occupancy
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int ENT_W  = ID_BITS + PRIORITY_BITS;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Sequencer and datapath registers
  state_t                   state_r, state_nxt;
  kind_t                    kind_r, kind_nxt;
  logic [ID_BITS-1:0]       id_r, id_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;       // request priority / saved run priority
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;         // entries held
  logic [CNT_W-1:0]         idx_r, idx_nxt;         // walk position
  logic                     found_r, found_nxt;
  logic                     ok_r, ok_nxt;
  logic [ID_COUNT-1:0]      present_r, present_nxt;
  logic [ID_BITS-1:0]       head_id_r, head_id_nxt;
  logic [PRIORITY_BITS-1:0] head_prio_r, head_prio_nxt;
  logic [ID_BITS-1:0]       tail_id_r, tail_id_nxt;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_status_r, out_status_nxt;
  logic                     out_empty_r, out_empty_nxt;
  logic [ID_BITS-1:0]       out_head_id_r, out_head_id_nxt;
  logic [PRIORITY_BITS-1:0] out_head_prio_r, out_head_prio_nxt;
  logic [ID_BITS-1:0]       out_tail_id_r, out_tail_id_nxt;
  logic [CNT_W-1:0]         out_occ_r, out_occ_nxt;

  // RAM port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;

  logic [ID_BITS-1:0]       rd_id;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic [CNT_W-1:0]         idx_m1, cnt_m1;
  logic                     out_free;

  assign rd_id    = ram_rdata[ENT_W-1 -: ID_BITS];
  assign rd_prio  = ram_rdata[PRIORITY_BITS-1:0];
  assign idx_m1   = idx_r - CNT_W'(1);
  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign out_free = !out_valid_r || !out_stall;

  psfq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (kind_r)
          KIND_INSERT: begin
            if (present_r[id_r] || (cnt_r == CAP_CNT)) state_nxt = ST_DONE;
            else state_nxt = ST_INS_RD;
          end
          KIND_REMOVE, KIND_REQUEUE: begin
            if (!present_r[id_r]) state_nxt = ST_DONE;
            else state_nxt = ST_SCAN_RD;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_INS_RD: begin
        if (idx_r == '0) state_nxt = ST_INS_PUT;
        else state_nxt = ST_INS_CMP;
      end
      ST_INS_CMP: begin
        if (rd_prio > prio_r) state_nxt = ST_INS_RD;
        else state_nxt = ST_INS_PUT;
      end
      ST_INS_PUT:  state_nxt = ST_HEAD_RD;
      ST_SCAN_RD: begin
        if (idx_r == cnt_r) state_nxt = ST_HEAD_RD;
        else state_nxt = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        // requeue stops at the first slot past its equal-priority run
        if (found_r && (kind_r == KIND_REQUEUE) && (rd_prio != prio_r))
          state_nxt = ST_HEAD_RD;
        else
          state_nxt = ST_SCAN_RD;
      end
      ST_HEAD_RD:  state_nxt = ST_TAIL_RD;
      ST_TAIL_RD:  state_nxt = ST_TAIL_CAP;
      ST_TAIL_CAP: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, RAM control and output register
  always_comb begin
    kind_nxt          = kind_r;
    id_nxt            = id_r;
    prio_nxt          = prio_r;
    cnt_nxt           = cnt_r;
    idx_nxt           = idx_r;
    found_nxt         = found_r;
    ok_nxt            = ok_r;
    present_nxt       = present_r;
    head_id_nxt       = head_id_r;
    head_prio_nxt     = head_prio_r;
    tail_id_nxt       = tail_id_r;
    out_status_nxt    = out_status_r;
    out_empty_nxt     = out_empty_r;
    out_head_id_nxt   = out_head_id_r;
    out_head_prio_nxt = out_head_prio_r;
    out_tail_id_nxt   = out_tail_id_r;
    out_occ_nxt       = out_occ_r;
    out_valid_nxt     = out_valid_r && out_stall;
    ram_we            = 1'b0;
    ram_waddr         = idx_m1[ADDR_W-1:0];
    ram_wdata         = ram_rdata;
    ram_raddr         = idx_r[ADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt  = kind_t'(in_kind);
          id_nxt    = in_entry_id;
          prio_nxt  = in_priority_req;
          found_nxt = 1'b0;
          ok_nxt    = 1'b0;
        end
      end
      ST_DECODE: begin
        idx_nxt = (kind_r == KIND_INSERT) ? cnt_r : '0;
      end
      ST_INS_RD: begin
        ram_raddr = idx_m1[ADDR_W-1:0];
      end
      ST_INS_CMP: begin
        // walk down from the tail, pushing larger priorities up one slot
        if (rd_prio > prio_r) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r[ADDR_W-1:0];
          ram_wdata = ram_rdata;
          idx_nxt   = idx_m1;
        end
      end
      ST_INS_PUT: begin
        ram_we              = 1'b1;
        ram_waddr           = idx_r[ADDR_W-1:0];
        ram_wdata           = {id_r, prio_r};
        cnt_nxt             = cnt_r + CNT_W'(1);
        present_nxt[id_r]   = 1'b1;
        ok_nxt              = 1'b1;
      end
      ST_SCAN_RD: begin
        if (idx_r == cnt_r) begin
          ok_nxt = 1'b1;
          if (kind_r == KIND_REMOVE) begin
            cnt_nxt           = cnt_m1;
            present_nxt[id_r] = 1'b0;
          end else begin
            // run reached the queue end: entry goes to the last slot
            ram_we    = 1'b1;
            ram_wdata = {id_r, prio_r};
          end
        end
      end
      ST_SCAN_CMP: begin
        idx_nxt = idx_r + CNT_W'(1);
        if (!found_r) begin
          if (rd_id == id_r) begin
            found_nxt = 1'b1;
            prio_nxt  = rd_prio;
          end
        end else if (kind_r == KIND_REMOVE) begin
          ram_we = 1'b1;
        end else begin
          ram_we = 1'b1;
          if (rd_prio != prio_r) begin
            ram_wdata = {id_r, prio_r};
            ok_nxt    = 1'b1;
          end
        end
      end
      ST_HEAD_RD: begin
        ram_raddr = '0;
      end
      ST_TAIL_RD: begin
        head_id_nxt   = rd_id;
        head_prio_nxt = rd_prio;
        ram_raddr     = cnt_m1[ADDR_W-1:0];
      end
      ST_TAIL_CAP: begin
        tail_id_nxt = rd_id;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_status_nxt    = ok_r ? STATUS_DONE : STATUS_IGNORED;
          out_empty_nxt     = (cnt_r == '0);
          out_head_id_nxt   = (cnt_r == '0) ? '0 : head_id_r;
          out_head_prio_nxt = (cnt_r == '0) ? '0 : head_prio_r;
          out_tail_id_nxt   = (cnt_r == '0) ? '0 : tail_id_r;
          out_occ_nxt       = cnt_r;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r          <= kind_nxt;
    id_r            <= id_nxt;
    prio_r          <= prio_nxt;
    idx_r           <= idx_nxt;
    found_r         <= found_nxt;
    ok_r            <= ok_nxt;
    head_id_r       <= head_id_nxt;
    head_prio_r     <= head_prio_nxt;
    tail_id_r       <= tail_id_nxt;
    out_status_r    <= out_status_nxt;
    out_empty_r     <= out_empty_nxt;
    out_head_id_r   <= out_head_id_nxt;
    out_head_prio_r <= out_head_prio_nxt;
    out_tail_id_r   <= out_tail_id_nxt;
    out_occ_r       <= out_occ_nxt;
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_is_empty      = out_empty_r;
  assign out_head_id       = out_head_id_r;
  assign out_head_priority = out_head_prio_r;
  assign out_tail_id       = out_tail_id_r;
  assign out_occupancy     = out_occ_r;

  // count never exceeds the slot storage
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CNT)
    else $error("held count above capacity");

  // membership map and count move together
  a_map_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(present_r) == int'(cnt_r))
    else $error("membership map disagrees with held count");

  // a result only appears out of the final sequencer state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside completion state");

  // slot writes stay within the held range plus one
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (CNT_W'(ram_waddr) <= cnt_r))
    else $error("slot write beyond held entries");

endmodule

@@ src/psfq_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module psfq_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
